[hdl/running_median_filter_top_defines.svh]
// assertion macros for the running median filter
// used by rmf_ctrl and rmf_datapath, no dependencies
`ifndef RUNNING_MEDIAN_FILTER_TOP_DEFINES_SVH
`define RUNNING_MEDIAN_FILTER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RMF_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define RMF_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/rmf_pkg.sv]
// running median filter package: constants, types, command and status structs
// no dependencies
package rmf_pkg;

  localparam int MAX_WINDOW = 15;
  localparam int MIN_WINDOW = 1;
  localparam int RESET_WINDOW = 5;
  localparam int SLOTS = MAX_WINDOW | 1;
  localparam int DATA_W = 16;
  localparam int SIZE_W = $clog2(SLOTS + 1);
  localparam int IDX_W = $clog2(SLOTS);

  typedef logic [DATA_W-1:0] data_t;
  typedef logic [SIZE_W-1:0] size_t;
  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic load_sample;
    logic clear_idx;
    logic inc_idx;
    logic load_median;
  } cmd_t;

  typedef struct packed {
    logic hit;
  } status_t;

endpackage

[hdl/rmf_sample_if.sv]
// input word channel: valid, ready and one sample
// depends on rmf_pkg
interface rmf_sample_if import rmf_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

[hdl/rmf_median_if.sv]
// output word channel: valid, ready and one median
// depends on rmf_pkg
interface rmf_median_if import rmf_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t median;

  modport source (output valid, output median, input ready);
  modport sink (input valid, input median, output ready);
endinterface

[hdl/rmf_datapath.sv]
// window slots, size register, scan index, rank compare and median register
// depends on rmf_pkg and running_median_filter_top_defines.svh
`include "running_median_filter_top_defines.svh"

module rmf_datapath import rmf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    cfg_we,
  input  size_t   cfg_wdata,
  input  data_t   sample,
  output data_t   median,
  input  cmd_t    cmd,
  output status_t status
);

  data_t win [SLOTS];
  size_t size;
  idx_t  next_slot;
  idx_t  idx;
  data_t median_q;

  size_t      cfg_size_next;
  idx_t       slot_inc;
  data_t      cand;
  logic [SLOTS-1:0] lt;
  logic [SLOTS-1:0] le;
  size_t      cnt_lt;
  size_t      cnt_le;
  size_t      rank;

  always_comb begin
    cfg_size_next = cfg_wdata;
    if (cfg_size_next < size_t'(MIN_WINDOW)) begin
      cfg_size_next = size_t'(MIN_WINDOW);
    end
    if (cfg_size_next > size_t'(MAX_WINDOW)) begin
      cfg_size_next = size_t'(MAX_WINDOW);
    end
    cfg_size_next = cfg_size_next | size_t'(1);
  end

  assign slot_inc = next_slot + idx_t'(1);

  always_comb begin
    cand = win[idx];
    for (int j = 0; j < SLOTS; j++) begin
      lt[j] = (size_t'(j) < size) && (win[j] < cand);
      le[j] = (size_t'(j) < size) && (win[j] <= cand);
    end
    cnt_lt = size_t'($countones(lt));
    cnt_le = size_t'($countones(le));
    rank = size >> 1;
    status.hit = (cnt_lt <= rank) && (rank < cnt_le);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < SLOTS; j++) begin
        win[j] <= '0;
      end
      size <= size_t'(RESET_WINDOW);
      next_slot <= '0;
      idx <= '0;
    end else begin
      if (cfg_we) begin
        size <= cfg_size_next;
      end
      if (cmd.load_sample) begin
        win[next_slot] <= sample;
      end
      priority if (cfg_we) begin
        next_slot <= '0;
      end else if (cmd.load_sample) begin
        next_slot <= (size_t'(slot_inc) >= size) ? '0 : slot_inc;
      end
      if (cmd.clear_idx) begin
        idx <= '0;
      end else if (cmd.inc_idx) begin
        idx <= idx + idx_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_median) begin
      median_q <= cand;
    end
  end

  assign median = median_q;

  `RMF_ASSERT_IMP(a_scan_in_window, clk, rst, cmd.inc_idx, (size_t'(idx) + size_t'(1)) < size, "scan index ran past the window")
  `RMF_ASSERT_IMP(a_size_odd, clk, rst, 1'b1, size[0], "window size is even")
  `RMF_ASSERT_IMP(a_slot_in_window, clk, rst, 1'b1, size_t'(next_slot) < size, "next slot outside the window")

endmodule

[hdl/rmf_ctrl.sv]
// controller: accepts a word, steps the rank scan, loads the output register
// depends on rmf_pkg and running_median_filter_top_defines.svh
`include "running_median_filter_top_defines.svh"

module rmf_ctrl import rmf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output cmd_t    cmd,
  input  status_t status
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   accept;
  logic   out_free;

  assign in_ready = (state == ST_IDLE);
  assign accept = in_ready && in_valid;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd.load_sample = accept;
    cmd.clear_idx = accept;
    cmd.inc_idx = (state == ST_SCAN) && !status.hit;
    cmd.load_median = (state == ST_SCAN) && status.hit && out_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cmd.load_median) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_median) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `RMF_ASSERT_NXT(a_accept_scan, clk, rst, accept, state == ST_SCAN, "accepted word did not start a scan")
  `RMF_ASSERT_IMP(a_load_on_hit, clk, rst, cmd.load_median, status.hit, "median loaded without a rank hit")
  `RMF_ASSERT_NXT(a_valid_after_load, clk, rst, cmd.load_median, out_valid, "loaded median not presented")

endmodule

[hdl/running_median_filter_top.sv]
// running median filter top level: controller plus datapath
// depends on rmf_pkg, rmf_sample_if, rmf_median_if, rmf_ctrl, rmf_datapath
//
//   channel   dir  payload          handshake
//   samples   in   sample[15:0]     valid/ready
//   medians   out  median[15:0]     valid/ready
//   cfg       in   cfg_wdata[3:0]   cfg_we, no wait
//
// a word is written into its slot on acceptance, then one candidate slot is
// ranked per cycle against the slots of the window; the scan stops at the slot
// of rank size/2; a new word is accepted only once the previous median is loaded
// a full output register stalls the scan on its hit until the median is taken
// synchronous reset clears all slots to zero and sets the window size to 5
module running_median_filter_top import rmf_pkg::*; (
  input logic         clk,
  input logic         rst,
  input logic         cfg_we,
  input size_t        cfg_wdata,
  rmf_sample_if.sink  samples,
  rmf_median_if.source medians
);

  cmd_t    cmd;
  status_t status;

  rmf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (medians.valid),
    .out_ready (medians.ready),
    .cmd       (cmd),
    .status    (status)
  );

  rmf_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .sample    (samples.sample),
    .median    (medians.median),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

[verif/tb_top.sv]
// self-checking bench for running_median_filter_top: a windowed median tracker
// predicts each median, checked per word across several window sizes and idle patterns
// depends on rmf_pkg, rmf_sample_if, rmf_median_if and the top level in hdl
module tb_top;
  import rmf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_PHASES = 16;
  localparam int PHASE_WORDS = 105;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  class window_median_board;
    data_t slots[SLOTS];
    int    size;
    int    next_slot;
    data_t pending_medians[$];
    int    mismatches;
    int    checked;

    function new();
      foreach (slots[i]) slots[i] = '0;
      size = RESET_WINDOW;
      next_slot = 0;
      mismatches = 0;
      checked = 0;
    endfunction

    function void write_size(size_t value);
      int s;
      s = int'(value[3:0]);
      if (s < MIN_WINDOW) s = MIN_WINDOW;
      if (s > MAX_WINDOW) s = MAX_WINDOW;
      size = s | 1;
      next_slot = 0;
    endfunction

    function data_t window_median();
      data_t sorted[SLOTS];
      data_t v;
      int    j;
      for (int i = 0; i < size; i++) begin
        v = slots[i];
        j = i;
        while (j > 0 && sorted[j-1] > v) begin
          sorted[j] = sorted[j-1];
          j--;
        end
        sorted[j] = v;
      end
      return sorted[size/2];
    endfunction

    function void take_sample(data_t value);
      if (next_slot >= size) next_slot = 0;
      slots[next_slot] = value;
      next_slot++;
      if (next_slot >= size) next_slot = 0;
      pending_medians.push_back(window_median());
    endfunction

    function void check_median(data_t actual);
      data_t expected;
      if (pending_medians.size() == 0) begin
        $error("median: no word expected, actual %h", actual);
        mismatches++;
      end else begin
        expected = pending_medians.pop_front();
        checked++;
        if (actual !== expected) begin
          $error("median: expected %h, actual %h", expected, actual);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic  clk;
  logic  rst;
  logic  cfg_we;
  size_t cfg_wdata;

  rmf_sample_if sample_ch();
  rmf_median_if median_ch();

  running_median_filter_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .samples   (sample_ch.sink),
    .medians   (median_ch.source)
  );

  window_median_board board = new();
  idle_mode_e idle_mode = IDLE_NONE;
  int cycle_count = 0;
  int size_writes = 0;
  int words_sent = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic int stall_pct(idle_mode_e mode, bit sender);
    case (mode)
      IDLE_SEND: return sender ? 88 : 0;
      IDLE_RECV: return sender ? 0 : 88;
      IDLE_BOTH: return 15;
      default:   return 0;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst && median_ch.valid && median_ch.ready) board.check_median(median_ch.median);
    median_ch.ready <= ($urandom_range(99) >= stall_pct(idle_mode, 1'b0));
  end

  function automatic data_t next_word();
    case ($urandom_range(9))
      5, 6:    return data_t'($urandom_range(7));
      7:       return $urandom_range(1) ? data_t'(16'hFFFF - $urandom_range(3))
                                        : data_t'($urandom_range(3));
      8:       return data_t'(16'h7FF8 + $urandom_range(15));
      default: return data_t'($urandom);
    endcase
  endfunction

  task automatic send_burst(input data_t words[$]);
    foreach (words[i]) begin
      if ($urandom_range(99) < stall_pct(idle_mode, 1'b1)) begin
        sample_ch.valid <= 1'b0;
        do @(posedge clk); while ($urandom_range(99) < stall_pct(idle_mode, 1'b1));
      end
      sample_ch.valid <= 1'b1;
      sample_ch.sample <= words[i];
      do @(posedge clk); while (!sample_ch.ready);
      board.take_sample(words[i]);
      words_sent++;
    end
    sample_ch.valid <= 1'b0;
  endtask

  task automatic write_window(input size_t value);
    while (board.pending_medians.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.write_size(value);
    size_writes++;
  endtask

  initial begin
    data_t words[$];
    size_t fixed_sizes[6];
    size_t value;

    fixed_sizes = '{4'd15, 4'd0, 4'hF, 4'd8, 4'd1, 4'd14};
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    sample_ch.valid <= 1'b0;
    sample_ch.sample <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset window of 5 with zero slots still counted
    send_burst('{16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFE});
    write_window(4'd0);
    send_burst('{16'h1234, 16'hFFFF, 16'h0000});
    // window of 15 with zeros in the untouched slots
    write_window(4'hF);
    send_burst('{16'hF000, 16'hE000, 16'hD000, 16'hC000, 16'h0FFF, 16'h8001});
    // even sizes round up, stale slots reappear
    write_window(4'd4);
    send_burst('{16'h0005, 16'h0003, 16'h0004});
    write_window(4'h2);
    send_burst('{16'hAAAA, 16'h5555, 16'hAAAA});

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      value = (p < 6) ? fixed_sizes[p] : size_t'($urandom_range(31));
      write_window(value);
      idle_mode = idle_mode_e'(p % 4);
      words.delete();
      repeat (PHASE_WORDS) words.push_back(next_word());
      send_burst(words);
    end

    while (board.pending_medians.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("run covered %0d samples under %0d window size writes", words_sent, size_writes);
    $display("%0d medians compared, %0d wrong", board.checked, board.mismatches);
    if (board.mismatches == 0 && board.pending_medians.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
